### src/ils_pkg.sv
// shared types and constants for the indexed list store
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [2:0] CMD_GET    = 3'd0;
  localparam logic [2:0] CMD_HEAD   = 3'd1;
  localparam logic [2:0] CMD_TAIL   = 3'd2;
  localparam logic [2:0] CMD_INSERT = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;

  localparam logic [CNT_W-1:0]  CAP_CNT    = CNT_W'(CAPACITY);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic [2:0]               command;
    logic [6:0]               position;
    logic signed [DATA_W-1:0] item_value;
  } ils_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     applied;
    logic [CNT_W-1:0]         entry_count;
  } ils_rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              get;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } ils_ctrl_t;

endpackage

### src/ils_cell.sv
// one slot of the list chain: holds an entry, shifts with its neighbors
module ils_cell
  import ils_pkg::*;
(
  input  logic              clk,
  input  ils_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]  idx,
  input  logic [DATA_W-1:0] left_value,
  input  logic [DATA_W-1:0] right_value,
  output logic [DATA_W-1:0] value,
  output logic [DATA_W-1:0] tap
);

  logic [DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    if (ctrl.ins) begin
      if (idx > ctrl.pos) begin
        value_next = left_value;
      end else if (idx == ctrl.pos) begin
        value_next = ctrl.value;
      end
    end else if (ctrl.del) begin
      if (idx >= ctrl.pos) begin
        value_next = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // only the addressed cell drives the read tree
  assign tap = (ctrl.get && idx == ctrl.pos) ? value : '0;

endmodule

### src/ils_gather.sv
// registered or-tree that collects the one active tap of the chain
module ils_gather
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic [DATA_W-1:0] taps [CAPACITY],
  output logic [DATA_W-1:0] gathered
);

  logic [DATA_W-1:0] grp      [NGROUP];
  logic [DATA_W-1:0] grp_next [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | taps[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp[g] <= grp_next[g];
    end
  end

  always_comb begin
    gathered = '0;
    for (int g = 0; g < NGROUP; g++) begin
      gathered = gathered | grp[g];
    end
  end

endmodule

### src/indexed_list_store_top.sv
// indexed list store: chain of cells with insert/delete shifting and indexed get
// flow: a request is taken in idle, shifts the cells in exec, and its result is
// registered from collect; busy covers the shift state and the state that finishes
// the registered read tree over the cells, so a new request waits for the last one
// reset: synchronous, clears count and control; cell contents stay undefined
// the result is strobed for one cycle and cannot be held off by the receiver
module indexed_list_store_top
  import ils_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  ils_req_t request,
  output logic     done,
  output ils_rsp_t result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COLLECT
  } state_t;

  state_t            state;
  ils_req_t          req;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              ok;
  logic              ok_next;
  logic              is_ins;
  logic [CNT_W-1:0]  ins_pos;
  ils_ctrl_t         ctrl;
  logic [DATA_W-1:0] ent  [CAPACITY];
  logic [DATA_W-1:0] taps [CAPACITY];
  logic [DATA_W-1:0] gathered;

  assign busy = (state != ST_IDLE);

  // decide the command against the current count
  always_comb begin
    ok_next    = 1'b0;
    is_ins     = 1'b0;
    ins_pos    = req.position;
    count_next = count;
    case (req.command)
      CMD_GET: begin
        ok_next = (req.position < count);
      end
      CMD_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
        ok_next = (count < CAP_CNT);
      end
      CMD_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = count;
        ok_next = (count < CAP_CNT);
      end
      CMD_INSERT: begin
        is_ins  = 1'b1;
        ok_next = (count < CAP_CNT) && (req.position <= count);
      end
      CMD_DELETE: begin
        ok_next = (req.position < count);
        if (ok_next) begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
    if (is_ins && ok_next) begin
      count_next = count + 1'b1;
    end
  end

  always_comb begin
    ctrl.ins   = (state == ST_EXEC) && is_ins && ok_next;
    ctrl.del   = (state == ST_EXEC) && (req.command == CMD_DELETE) && ok_next;
    ctrl.get   = (state == ST_EXEC) && (req.command == CMD_GET);
    ctrl.pos   = ins_pos;
    ctrl.value = req.item_value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_value;
    logic [DATA_W-1:0] right_value;
    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_left
      assign left_value = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_right
      assign right_value = ent[i+1];
    end
    ils_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .idx         (CNT_W'(i)),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (ent[i]),
      .tap         (taps[i])
    );
  end

  ils_gather u_gather (
    .clk      (clk),
    .taps     (taps),
    .gathered (gathered)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ok    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            req   <= request;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          ok    <= ok_next;
          count <= count_next;
          state <= ST_COLLECT;
        end
        ST_COLLECT: begin
          done               <= 1'b1;
          result.applied     <= ok;
          result.entry_count <= count;
          result.read_value  <= (ok && req.command == CMD_GET) ? gathered : MISS_VALUE;
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy ##1 busy ##1 (!busy && done))
    else $error("request did not complete in three cycles");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_count == count))
    else $error("reported count differs from stored count");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (done && !result.applied) |-> (result.read_value == MISS_VALUE))
    else $error("rejected request returned a value");

endmodule

### verif/indexed_list_store_top_tb.sv
// self-checking testbench for the indexed list store: directed and random command streams
`timescale 1ns / 1ps

module indexed_list_store_top_tb;
  import ils_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;

  // command codes the block does not define
  localparam logic [2:0] CMD_UNKNOWN_LO  = CMD_DELETE + 3'd1;
  localparam logic [2:0] CMD_UNKNOWN_MID = CMD_DELETE + 3'd2;
  localparam logic [2:0] CMD_UNKNOWN_HI  = 3'b111;

  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} stim_mode_t;

  class ils_scoreboard;
    logic [DATA_W-1:0] shadow_entries [CAPACITY];
    int unsigned       shadow_count;
    ils_rsp_t          pending_results [$];
    int unsigned       errors;

    function new();
      shadow_count = 0;
      errors       = 0;
    endfunction

    function bit insert_entry(int unsigned where, logic [DATA_W-1:0] value);
      if (shadow_count >= CAPACITY || where > shadow_count) return 1'b0;
      for (int i = int'(shadow_count); i > int'(where); i--)
        shadow_entries[i] = shadow_entries[i-1];
      shadow_entries[where] = value;
      shadow_count++;
      return 1'b1;
    endfunction

    // work out the result of an accepted request and queue it
    function void note_request(ils_req_t req);
      ils_rsp_t want;
      want.read_value = MISS_VALUE;
      want.applied    = 1'b0;
      case (req.command)
        CMD_GET: begin
          if (req.position < shadow_count) begin
            want.read_value = shadow_entries[req.position];
            want.applied    = 1'b1;
          end
        end
        CMD_HEAD:   want.applied = insert_entry(0, req.item_value);
        CMD_TAIL:   want.applied = insert_entry(shadow_count, req.item_value);
        CMD_INSERT: want.applied = insert_entry(req.position, req.item_value);
        CMD_DELETE: begin
          if (req.position < shadow_count) begin
            for (int i = int'(req.position); i < int'(shadow_count) - 1; i++)
              shadow_entries[i] = shadow_entries[i+1];
            shadow_count--;
            want.applied = 1'b1;
          end
        end
        default: ;
      endcase
      want.entry_count = CNT_W'(shadow_count);
      pending_results.push_back(want);
    endfunction

    function void check_result(ils_rsp_t got);
      ils_rsp_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: read_value %0d applied %0d count %0d",
               got.read_value, got.applied, got.entry_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
        errors++;
      end
      if (got.applied !== want.applied) begin
        $error("applied: expected %0d, actual %0d", want.applied, got.applied);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  ils_req_t request;
  logic     done;
  ils_rsp_t result;

  ils_scoreboard sb;
  int unsigned   cycle_count = 0;

  indexed_list_store_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (start && !busy) sb.note_request(request);
      if (done) sb.check_result(result);
    end
  end

  function automatic ils_req_t make_req(logic [2:0] cmd, logic [6:0] pos,
                                        logic [DATA_W-1:0] value);
    ils_req_t req;
    req.command    = cmd;
    req.position   = pos;
    req.item_value = value;
    return req;
  endfunction

  task automatic send(ils_req_t req);
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_results();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return VAL_MAX;
      3:       return VAL_MIN;
      default: return $urandom();
    endcase
  endfunction

  // mostly in-range positions so edits reach every depth of the list
  function automatic logic [6:0] pick_position(int unsigned count);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 7'($urandom_range(0, count));
    if (r < 95) return 7'($urandom_range(0, CAPACITY));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic ils_req_t random_req(stim_mode_t mode, int unsigned count);
    int unsigned r;
    logic [2:0]  cmd;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if      (r < 30) cmd = CMD_TAIL;
        else if (r < 55) cmd = CMD_HEAD;
        else if (r < 88) cmd = CMD_INSERT;
        else if (r < 94) cmd = CMD_GET;
        else if (r < 98) cmd = CMD_DELETE;
        else             cmd = 3'(CMD_UNKNOWN_LO + $urandom_range(0, 2));
      end
      MODE_DRAIN: begin
        if      (r < 60) cmd = CMD_DELETE;
        else if (r < 80) cmd = CMD_GET;
        else if (r < 85) cmd = CMD_HEAD;
        else if (r < 90) cmd = CMD_TAIL;
        else if (r < 95) cmd = CMD_INSERT;
        else             cmd = 3'(CMD_UNKNOWN_LO + $urandom_range(0, 2));
      end
      default: begin
        if      (r < 25) cmd = CMD_GET;
        else if (r < 40) cmd = CMD_HEAD;
        else if (r < 55) cmd = CMD_TAIL;
        else if (r < 72) cmd = CMD_INSERT;
        else if (r < 94) cmd = CMD_DELETE;
        else             cmd = 3'(CMD_UNKNOWN_LO + $urandom_range(0, 2));
      end
    endcase
    return make_req(cmd, pick_position(count), pick_value());
  endfunction

  initial begin
    int unsigned sent;
    int unsigned block_len;
    stim_mode_t  mode;
    bit          no_gaps;

    sb      = new();
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty store, then the only entry coming and going
    send(make_req(CMD_GET,    7'd0,  32'd0));
    send(make_req(CMD_DELETE, 7'd0,  32'd0));
    send(make_req(CMD_INSERT, 7'd1,  32'd3));
    send(make_req(CMD_INSERT, 7'd0,  VAL_MAX));
    send(make_req(CMD_GET,    7'd0,  32'd0));
    send(make_req(CMD_DELETE, 7'd0,  32'd0));
    idle(3);
    // tail add after emptying must land in slot 0
    send(make_req(CMD_TAIL,   7'd90, VAL_MIN));
    send(make_req(CMD_GET,    7'd0,  32'd0));
    send(make_req(CMD_HEAD,   7'd127, '1));
    send(make_req(CMD_TAIL,   7'd0,  32'd0));
    send(make_req(CMD_INSERT, 7'd3,  32'd5));
    send(make_req(CMD_INSERT, 7'd2,  32'h5a5a_5a5a));
    send(make_req(CMD_GET,    7'd2,  32'd0));
    send(make_req(CMD_GET,    7'd5,  32'd0));
    send(make_req(CMD_GET,    7'd127, VAL_MAX));
    send(make_req(CMD_DELETE, 7'd5,  32'd0));
    send(make_req(CMD_DELETE, 7'd1,  32'd0));
    send(make_req(CMD_DELETE, 7'd3,  32'd0));
    send(make_req(CMD_UNKNOWN_LO,  7'd0, 32'd1));
    send(make_req(CMD_UNKNOWN_MID, 7'd1, '1));
    send(make_req(CMD_UNKNOWN_HI,  7'd127, VAL_MIN));
    send(make_req(CMD_INSERT, 7'd64, 32'd9));
    send(make_req(CMD_GET,    7'd3,  32'd0));
    send(make_req(CMD_GET,    7'd0,  32'd0));
    send(make_req(CMD_HEAD,   7'd0,  32'h1234_5678));

    // hold off until the block has answered everything
    idle(1);
    drain_results();

    // first block fills the store past capacity; later blocks wander
    sent = 0;
    mode = MODE_FILL;
    block_len = 130;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < int'(block_len) && sent < RANDOM_ITEMS; i++) begin
        send(random_req(mode, sb.shadow_count));
        sent++;
        if (!no_gaps) idle(pick_gap());
      end
      if ($urandom_range(0, 2) == 0) begin
        idle(1);
        drain_results();
      end
      case ($urandom_range(0, 2))
        0:       mode = MODE_FILL;
        1:       mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      block_len = (mode == MODE_FILL) ? $urandom_range(60, 120) : $urandom_range(20, 80);
    end

    idle(1);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
